// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

// File: design/irqps_pkg.sv
// ----------------------------------------------------------------------------
// irqps_pkg
// types and constants of the interrupt enable and pending scan block
// ----------------------------------------------------------------------------
package irqps_pkg;

   localparam int DEF_NUM_SHARED_LINES = 64;
   localparam int DEF_NUM_BASIC_LINES  = 8;

   localparam int GROUP_BITS = 32;
   localparam int IDX_W      = 5;
   localparam int IRQ_W      = 7;

   localparam logic [1:0] OP_ENABLE  = 2'd0;
   localparam logic [1:0] OP_DISABLE = 2'd1;
   localparam logic [1:0] OP_SCAN    = 2'd2;

   localparam logic [1:0] GRP_SHARED0 = 2'd0;
   localparam logic [1:0] GRP_SHARED1 = 2'd1;
   localparam logic [1:0] GRP_BASIC   = 2'd2;

   localparam logic [IRQ_W-1:0] BASE_SHARED0 = 7'd0;
   localparam logic [IRQ_W-1:0] BASE_SHARED1 = 7'd32;
   localparam logic [IRQ_W-1:0] BASE_BASIC   = 7'd64;

   typedef struct packed {
      logic [1:0]            operation;
      logic [IRQ_W-1:0]      irq_number;
      logic [1:0]            group_select;
      logic [GROUP_BITS-1:0] pending_word;
   } req_word_type;

   typedef struct packed {
      logic [IRQ_W-1:0] dispatched_irq;
      logic             found;
      logic             last;
   } rsp_word_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

endpackage

// File: design/irq_enable_and_pending_scan.sv
// ----------------------------------------------------------------------------
// irq_enable_and_pending_scan
// interrupt enable bits with a priority scan of one group's pending word
// ----------------------------------------------------------------------------
// req channel: one word per handshake; enable and disable words set or clear
//   the enable bit of one line and give no result; a scan word ands the
//   group's pending word with its enable bits
// rsp channel: a scan gives one word per qualifying line, highest line
//   first, with last on the final one; with nothing qualifying it gives one
//   word with found clear and last set
// scan: on accept the masked pending word is registered in rem_ff, and in
//   ST_EMIT each result is registered in the output register; enable and
//   disable never raise req_stall; the single priority encoder retires one
//   line per cycle unless rsp_stall holds the output; req_stall is high meanwhile
// rsp_stall holds the output register and the scan waits for it
// reset clears all enable bits, the scan state and rsp_valid
// ----------------------------------------------------------------------------
module irq_enable_and_pending_scan
   import irqps_pkg::*;
#(
   parameter int NUM_SHARED_LINES = DEF_NUM_SHARED_LINES,
   parameter int NUM_BASIC_LINES  = DEF_NUM_BASIC_LINES
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   localparam int              G1_LINES   = NUM_SHARED_LINES - GROUP_BITS;
   localparam logic [63:0]     G1_MASK_W  = (64'd1 << G1_LINES) - 64'd1;
   localparam logic [GROUP_BITS-1:0] G1_MASK = G1_MASK_W[GROUP_BITS-1:0];

   state_type                    state_ff, state_in;
   logic [GROUP_BITS-1:0]        en_g0_ff, en_g0_in;
   logic [GROUP_BITS-1:0]        en_g1_ff, en_g1_in;
   logic [NUM_BASIC_LINES-1:0]   en_basic_ff, en_basic_in;
   logic [GROUP_BITS-1:0]        rem_ff, rem_in;
   logic [IRQ_W-1:0]             base_ff, base_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_word_type                 rsp_word_ff, rsp_word_in;

   logic                         accept;
   logic                         slot_free;
   logic [GROUP_BITS-1:0]        sel_g0, sel_g1;
   logic [NUM_BASIC_LINES-1:0]   sel_basic;
   logic [IDX_W-1:0]             top_idx;
   logic [GROUP_BITS-1:0]        rem_left;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // one-hot line select per group, out-of-range lines select nothing
   always_comb begin
      sel_g0    = GROUP_BITS'(32'd1 << req_word.irq_number[IDX_W-1:0]);
      sel_g1    = GROUP_BITS'(32'd1 << req_word.irq_number[IDX_W-1:0]) & G1_MASK;
      sel_basic = NUM_BASIC_LINES'(64'd1 << req_word.irq_number[5:0]);
      if (req_word.irq_number[6]) begin
         sel_g0 = '0;
         sel_g1 = '0;
      end else if (req_word.irq_number[5]) begin
         sel_g0    = '0;
         sel_basic = '0;
      end else begin
         sel_g1    = '0;
         sel_basic = '0;
      end
   end

   // shared priority encoder over the remaining lines
   always_comb begin
      top_idx = '0;
      for (int i = 0; i < GROUP_BITS; i++) begin
         if (rem_ff[i]) begin
            top_idx = IDX_W'(i);
         end
      end
      rem_left = rem_ff & ~(GROUP_BITS'(32'd1 << top_idx));
   end

   always_comb begin
      state_in     = state_ff;
      en_g0_in     = en_g0_ff;
      en_g1_in     = en_g1_ff;
      en_basic_in  = en_basic_ff;
      rem_in       = rem_ff;
      base_in      = base_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_word.operation == OP_ENABLE) begin
                  en_g0_in    = en_g0_ff | sel_g0;
                  en_g1_in    = en_g1_ff | sel_g1;
                  en_basic_in = en_basic_ff | sel_basic;
               end else if (req_word.operation == OP_DISABLE) begin
                  en_g0_in    = en_g0_ff & ~sel_g0;
                  en_g1_in    = en_g1_ff & ~sel_g1;
                  en_basic_in = en_basic_ff & ~sel_basic;
               end else if (req_word.operation == OP_SCAN) begin
                  state_in = ST_EMIT;
                  case (req_word.group_select)
                     GRP_SHARED0: begin
                        rem_in  = req_word.pending_word & en_g0_ff;
                        base_in = BASE_SHARED0;
                     end
                     GRP_SHARED1: begin
                        rem_in  = req_word.pending_word & en_g1_ff;
                        base_in = BASE_SHARED1;
                     end
                     GRP_BASIC: begin
                        rem_in  = req_word.pending_word & GROUP_BITS'(en_basic_ff);
                        base_in = BASE_BASIC;
                     end
                     default: begin
                        rem_in  = '0;
                        base_in = BASE_SHARED0;
                     end
                  endcase
               end
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (rem_ff == '0) begin
                  rsp_word_in.dispatched_irq = '0;
                  rsp_word_in.found          = 1'b0;
                  rsp_word_in.last           = 1'b1;
                  state_in                   = ST_IDLE;
               end else begin
                  rsp_word_in.dispatched_irq = base_ff + IRQ_W'(top_idx);
                  rsp_word_in.found          = 1'b1;
                  rsp_word_in.last           = (rem_left == '0);
                  rem_in                     = rem_left;
                  if (rem_left == '0) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         en_g0_ff     <= '0;
         en_g1_ff     <= '0;
         en_basic_ff  <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         en_g0_ff     <= en_g0_in;
         en_g1_ff     <= en_g1_in;
         en_basic_ff  <= en_basic_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      rsp_word_ff <= rsp_word_in;
   end

endmodule

// File: design/irqps_checker.sv
// ----------------------------------------------------------------------------
// irqps_checker
// port-level checks of the interrupt enable and pending scan block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module irqps_checker
   import irqps_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_word_type req_word,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
   `ASSERT_CLK(a_scan_busy, clock, reset, req_valid && !req_stall && req_word.operation == OP_SCAN |=> req_stall)
   `ASSERT_CLK(a_cfg_free, clock, reset, req_valid && !req_stall && req_word.operation != OP_SCAN |=> !req_stall)
   `ASSERT_NEVER(a_empty_last, clock, reset, rsp_valid && !rsp_word.found && !rsp_word.last)
   `ASSERT_NEVER(a_empty_zero, clock, reset, rsp_valid && !rsp_word.found && rsp_word.dispatched_irq != '0)

endmodule

bind irq_enable_and_pending_scan irqps_checker u_irqps_checker (.*);
